// ===== src/cip_pkg.sv =====
package cip_pkg;

  // Width of the CORDIC x, y and residual angle words (Q1.30 plus headroom)
  localparam int TRIG_W = 33;

  // Deepest CORDIC chain the arctangent table supports
  localparam int MAX_STAGES = 24;

  // Start vector magnitude, 0.6072529350 in Q1.30
  localparam logic signed [TRIG_W-1:0] K_INIT = 33'sd652032874;

  // Quarter and half turn in 2^32 units per turn
  localparam logic signed [TRIG_W-1:0] QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [TRIG_W-1:0] HALF_TURN    = 33'sd2147483648;

  // atan(2^-i) in 2^32 units per turn, rounded to nearest
  localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Rotation axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_CENTER_X        = 3'd0;
  localparam logic [2:0] REG_CENTER_Y        = 3'd1;
  localparam logic [2:0] REG_CENTER_Z        = 3'd2;
  localparam logic [2:0] REG_CIRCLE_RADIUS   = 3'd3;
  localparam logic [2:0] REG_START_ANGLE     = 3'd4;
  localparam logic [2:0] REG_STEP_ANGLE      = 3'd5;
  localparam logic [2:0] REG_AXIS_SELECT     = 3'd6;
  localparam logic [2:0] REG_FOLLOW_ROTATION = 3'd7;

  // State carried from one CORDIC cell to the next
  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
    logic                     neg;
  } cip_vec_t;

endpackage

// ===== src/circular_item_placement.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// input    | in_valid, in_stall  | item_index
// output   | out_valid, out_stall| pos_x, pos_y, pos_z, orient_valid, orient_angle
// config   | wr_en               | wr_index, wr_data
//
// One request enters per cycle while the output is not stalled; the stages are angle multiply,
// angle add and quadrant fold, one register per CORDIC cell, radius multiply,
// rounding, and the center add with saturation into the output register.
// Every stage holds its own valid bit, so bubbles close up behind a stalled output.
// Reset is synchronous: it empties the pipeline and loads the register defaults.
module circular_item_placement #(
  parameter int ANGLE_BITS  = 16,
  parameter int COORD_BITS  = 32,
  parameter int TRIG_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [2:0]                   wr_index,
  input  logic [31:0]                  wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [15:0]                  item_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic signed [COORD_BITS-1:0] pos_z,
  output logic                         orient_valid,
  output logic [ANGLE_BITS-1:0]        orient_angle
);
  import cip_pkg::*;

  localparam int PROD_W = 65;
  localparam int TERM_W = 34;
  localparam int SUM_W  = 36;
  localparam int WIDE_W = ((COORD_BITS > SUM_W) ? COORD_BITS : SUM_W) + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2**29);
  localparam logic signed [WIDE_W-1:0] SAT_HI =
    {{(WIDE_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[COORD_BITS-1:0];
    end
    if (v < SAT_LO) begin
      return SAT_LO[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // Configuration registers
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        circle_radius;
  logic [15:0]        start_angle;
  logic signed [15:0] step_angle;
  logic [1:0]         axis_select;
  logic               follow_rotation;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      center_z        <= '0;
      circle_radius   <= '0;
      start_angle     <= '0;
      step_angle      <= 16'sd1;
      axis_select     <= AXIS_Z;
      follow_rotation <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        REG_CENTER_X:        center_x        <= wr_data;
        REG_CENTER_Y:        center_y        <= wr_data;
        REG_CENTER_Z:        center_z        <= wr_data;
        REG_CIRCLE_RADIUS:   circle_radius   <= wr_data[30:0];
        REG_START_ANGLE:     start_angle     <= wr_data[15:0];
        REG_STEP_ANGLE:      step_angle      <= wr_data[15:0];
        REG_AXIS_SELECT:     axis_select     <= wr_data[1:0];
        REG_FOLLOW_ROTATION: follow_rotation <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake wires
  logic s0_valid, s0_ready;
  logic b0_valid, b0_ready;
  logic b1_valid, b1_ready;
  logic b2_ready;

  logic                  cell_valid [TRIG_STAGES+1];
  logic                  cell_ready [TRIG_STAGES+1];
  cip_vec_t              cell_vec   [TRIG_STAGES+1];
  logic [ANGLE_BITS-1:0] cell_angle [TRIG_STAGES+1];

  // Stage 0: index times step, kept modulo one turn
  logic signed [32:0]    prod_c;
  logic [ANGLE_BITS-1:0] s0_prod;

  assign prod_c   = $signed({1'b0, item_index}) * step_angle;
  assign s0_ready = !s0_valid || cell_ready[0];
  assign in_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      s0_prod <= prod_c[ANGLE_BITS-1:0];
    end
  end

  // Stage 1: add start angle, fold into the right half plane
  logic [ANGLE_BITS-1:0]    ang_c;
  logic [31:0]              turn_c;
  logic signed [TRIG_W-1:0] z_raw;
  cip_vec_t                 seed_c;

  always_comb begin
    ang_c      = s0_prod + ANGLE_BITS'(start_angle);
    turn_c     = {ang_c, {(32-ANGLE_BITS){1'b0}}};
    z_raw      = TRIG_W'($signed(turn_c));
    seed_c.x   = K_INIT;
    seed_c.y   = '0;
    seed_c.z   = z_raw;
    seed_c.neg = 1'b0;
    if (z_raw > QUARTER_TURN) begin
      seed_c.z   = z_raw - HALF_TURN;
      seed_c.neg = 1'b1;
    end else if (z_raw < -QUARTER_TURN) begin
      seed_c.z   = z_raw + HALF_TURN;
      seed_c.neg = 1'b1;
    end
  end

  assign cell_ready[0] = !cell_valid[0] || cell_ready[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid[0] <= 1'b0;
    end else if (cell_ready[0]) begin
      cell_valid[0] <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_ready[0] && s0_valid) begin
      cell_vec[0]   <= seed_c;
      cell_angle[0] <= ang_c;
    end
  end

  // CORDIC chain, one micro-rotation per cell
  for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_cell
    logic next_ready;

    if (k == TRIG_STAGES - 1) begin : g_last
      assign next_ready = b0_ready;
    end else begin : g_mid
      assign next_ready = cell_ready[k+2];
    end

    cip_cordic_cell #(
      .STAGE      (k),
      .ANGLE_BITS (ANGLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[k]),
      .in_vec    (cell_vec[k]),
      .in_angle  (cell_angle[k]),
      .in_ready  (cell_ready[k+1]),
      .out_ready (next_ready),
      .out_valid (cell_valid[k+1]),
      .out_vec   (cell_vec[k+1]),
      .out_angle (cell_angle[k+1])
    );
  end

  // Back stage 0: radius times cosine and sine
  logic signed [31:0]       radius_s;
  logic signed [PROD_W-1:0] mul_c;
  logic signed [PROD_W-1:0] mul_s;
  logic signed [PROD_W-1:0] b0_pc;
  logic signed [PROD_W-1:0] b0_ps;
  logic                     b0_neg;
  logic [ANGLE_BITS-1:0]    b0_angle;

  assign radius_s = $signed({1'b0, circle_radius});
  assign mul_c    = radius_s * $signed(cell_vec[TRIG_STAGES].x);
  assign mul_s    = radius_s * $signed(cell_vec[TRIG_STAGES].y);
  assign b0_ready = !b0_valid || b1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
    end else if (b0_ready) begin
      b0_valid <= cell_valid[TRIG_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (b0_ready && cell_valid[TRIG_STAGES]) begin
      b0_pc    <= mul_c;
      b0_ps    <= mul_s;
      b0_neg   <= cell_vec[TRIG_STAGES].neg;
      b0_angle <= cell_angle[TRIG_STAGES];
    end
  end

  // Back stage 1: undo the fold and round half up at bit 30
  logic signed [PROD_W-1:0] rnd_c;
  logic signed [PROD_W-1:0] rnd_s;
  logic signed [TERM_W-1:0] b1_tc;
  logic signed [TERM_W-1:0] b1_ts;
  logic [ANGLE_BITS-1:0]    b1_angle;

  assign rnd_c    = b0_neg ? (ROUND_HALF - b0_pc) : (b0_pc + ROUND_HALF);
  assign rnd_s    = b0_neg ? (ROUND_HALF - b0_ps) : (b0_ps + ROUND_HALF);
  assign b1_ready = !b1_valid || b2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_ready) begin
      b1_valid <= b0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_ready && b0_valid) begin
      b1_tc    <= rnd_c[30 +: TERM_W];
      b1_ts    <= rnd_s[30 +: TERM_W];
      b1_angle <= b0_angle;
    end
  end

  // Back stage 2: route terms to the axis plane, add center, saturate
  logic signed [TERM_W-1:0] term_x;
  logic signed [TERM_W-1:0] term_y;
  logic signed [TERM_W-1:0] term_z;
  logic signed [WIDE_W-1:0] sum_x;
  logic signed [WIDE_W-1:0] sum_y;
  logic signed [WIDE_W-1:0] sum_z;
  logic                     axis_ok;

  always_comb begin
    term_x = '0;
    term_y = '0;
    term_z = '0;
    case (axis_select)
      AXIS_X: begin
        term_y = b1_tc;
        term_z = b1_ts;
      end
      AXIS_Y: begin
        term_z = b1_tc;
        term_x = b1_ts;
      end
      AXIS_Z: begin
        term_x = b1_tc;
        term_y = b1_ts;
      end
      default: ;
    endcase
    sum_x = WIDE_W'(center_x) + WIDE_W'(term_x);
    sum_y = WIDE_W'(center_y) + WIDE_W'(term_y);
    sum_z = WIDE_W'(center_z) + WIDE_W'(term_z);
  end

  assign axis_ok  = (axis_select == AXIS_X) || (axis_select == AXIS_Y) ||
                    (axis_select == AXIS_Z);
  assign b2_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b2_ready) begin
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_ready && b1_valid) begin
      pos_x        <= sat_coord(sum_x);
      pos_y        <= sat_coord(sum_y);
      pos_z        <= sat_coord(sum_z);
      orient_valid <= axis_ok && follow_rotation;
      orient_angle <= (axis_ok && follow_rotation) ? b1_angle : '0;
    end
  end

endmodule

// ===== src/cip_cordic_cell.sv =====
module cip_cordic_cell #(
  parameter int STAGE      = 0,
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  cip_pkg::cip_vec_t     in_vec,
  input  logic [ANGLE_BITS-1:0] in_angle,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output cip_pkg::cip_vec_t     out_vec,
  output logic [ANGLE_BITS-1:0] out_angle
);
  import cip_pkg::*;

  localparam logic signed [TRIG_W-1:0] ATAN_STEP = TRIG_W'(ATAN_TAB[STAGE]);

  logic signed [TRIG_W-1:0] dx;
  logic signed [TRIG_W-1:0] dy;
  cip_vec_t                 rot;

  // Rotate towards zero residual angle by one micro-rotation
  always_comb begin
    dx  = $signed(in_vec.y) >>> STAGE;
    dy  = $signed(in_vec.x) >>> STAGE;
    rot = in_vec;
    if (!in_vec.z[TRIG_W-1]) begin
      rot.x = in_vec.x - dx;
      rot.y = in_vec.y + dy;
      rot.z = in_vec.z - ATAN_STEP;
    end else begin
      rot.x = in_vec.x + dx;
      rot.y = in_vec.y - dy;
      rot.z = in_vec.z + ATAN_STEP;
    end
  end

  // Take a new request when empty or when the neighbour takes ours
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_vec   <= rot;
      out_angle <= in_angle;
    end
  end

endmodule

// ===== src/cip_checker.sv =====
module cip_checker #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] pos_x,
  input logic signed [COORD_BITS-1:0] pos_y,
  input logic signed [COORD_BITS-1:0] pos_z,
  input logic                         orient_valid,
  input logic [ANGLE_BITS-1:0]        orient_angle
);

  // Reset drains the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // An empty output register means every stage can move, so input is never held
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with output empty");

  // Identity orientation carries a zero angle
  a_identity_angle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !orient_valid) |-> (orient_angle == '0))
    else $error("nonzero angle with identity orientation");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(pos_x) && $stable(pos_y) &&
                                  $stable(pos_z) && $stable(orient_valid) &&
                                  $stable(orient_angle)))
    else $error("stalled result changed");

endmodule

bind circular_item_placement cip_checker #(
  .ANGLE_BITS (ANGLE_BITS),
  .COORD_BITS (COORD_BITS)
) u_cip_checker (.*);

// ===== tb/sv/circular_item_placement_tb.sv =====
module circular_item_placement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cip_pkg::*;

  // Rotation axis code that selects no plane
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // CORDIC arithmetic in 2^32 units per turn
  localparam int     CORDIC_STAGES = 16;
  localparam longint ANG_TURN      = 64'sd4294967296;
  localparam longint ANG_HALF      = 64'sd2147483648;
  localparam longint ANG_QUARTER   = 64'sd1073741824;
  localparam longint CORDIC_GAIN0  = 64'sd652032874;
  localparam longint ROUND_BIAS    = 64'sd536870912;
  localparam longint COORD_MAX     = 64'sd2147483647;
  localparam longint COORD_MIN     = -64'sd2147483648;
  localparam longint ARCTAN [CORDIC_STAGES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  localparam int PIPE_SETTLE     = 30;
  localparam int HOLD_CYCLES     = 80;
  localparam int STUCK_LIMIT     = 1000;
  localparam int RANDOM_PHASES   = 16;
  localparam int ITEMS_PER_PHASE = 108;
  localparam int QUIET_PHASE     = 13;
  localparam int HOLD_PHASE      = 1;
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    logic [15:0]        idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               ov;
    logic [15:0]        oa;
  } placement_t;

  logic clk;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [31:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] item_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic orient_valid;
  logic [15:0] orient_angle;

  // Mirror of the configuration registers
  logic signed [31:0] cfg_cx = '0;
  logic signed [31:0] cfg_cy = '0;
  logic signed [31:0] cfg_cz = '0;
  logic [30:0]        cfg_radius = '0;
  logic [15:0]        cfg_start = '0;
  logic signed [15:0] cfg_step = 16'sd1;
  logic [1:0]         cfg_axis = AXIS_Z;
  logic               cfg_follow = 1'b1;

  logic [15:0] index_q [$];
  placement_t  place_q [$];

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit quiet = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;

  circular_item_placement u_top (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .item_index   (item_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .orient_valid (orient_valid),
    .orient_angle (orient_angle)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX[31:0];
    if (v < COORD_MIN) return COORD_MIN[31:0];
    return v[31:0];
  endfunction

  // Place one item on the circle under the current register settings
  function automatic placement_t place_item(input logic [15:0] idx);
    placement_t p;
    longint ang, zr, cs, sn, dx, dy, tc, ts, px, py, pz;
    bit flip;
    ang = (longint'(cfg_start) + longint'(idx) * longint'(cfg_step)) & 64'hFFFF;
    zr = ang << 16;
    if (zr >= ANG_HALF) zr = zr - ANG_TURN;
    cs = CORDIC_GAIN0;
    sn = 0;
    flip = 1'b0;
    // fold into the right half plane
    if (zr > ANG_QUARTER) begin
      zr = zr - ANG_HALF;
      flip = 1'b1;
    end else if (zr < -ANG_QUARTER) begin
      zr = zr + ANG_HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = sn >>> i;
      dy = cs >>> i;
      if (zr >= 0) begin
        cs = cs - dx;
        sn = sn + dy;
        zr = zr - ARCTAN[i];
      end else begin
        cs = cs + dx;
        sn = sn - dy;
        zr = zr + ARCTAN[i];
      end
    end
    if (flip) begin
      cs = -cs;
      sn = -sn;
    end
    tc = (longint'(cfg_radius) * cs + ROUND_BIAS) >>> 30;
    ts = (longint'(cfg_radius) * sn + ROUND_BIAS) >>> 30;
    px = longint'(cfg_cx);
    py = longint'(cfg_cy);
    pz = longint'(cfg_cz);
    case (cfg_axis)
      AXIS_X: begin
        py = py + tc;
        pz = pz + ts;
      end
      AXIS_Y: begin
        pz = pz + tc;
        px = px + ts;
      end
      AXIS_Z: begin
        px = px + tc;
        py = py + ts;
      end
      default: ;
    endcase
    p.idx = idx;
    p.x = clamp_coord(px);
    p.y = clamp_coord(py);
    p.z = clamp_coord(pz);
    if (cfg_axis != AXIS_NONE && cfg_follow) begin
      p.ov = 1'b1;
      p.oa = ang[15:0];
    end else begin
      p.ov = 1'b0;
      p.oa = '0;
    end
    return p;
  endfunction

  // Sample both handshakes, predict accepted requests, check results, watch for a hang
  always @(posedge clk) begin
    placement_t want;
    in_fire = !rst && in_valid && !in_stall;
    out_fire = !rst && out_valid && !out_stall;
    if (in_fire) place_q = {place_q, place_item(item_index)};
    if (out_fire) begin
      if (place_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: x=%0d y=%0d z=%0d ov=%0d oa=%0d",
                   pos_x, pos_y, pos_z, orient_valid, orient_angle);
      end else begin
        want = place_q.pop_front();
        if (pos_x !== want.x || pos_y !== want.y || pos_z !== want.z ||
            orient_valid !== want.ov || orient_angle !== want.oa) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch on item %0d: exp x=%0d y=%0d z=%0d ov=%0d oa=%0d",
                     want.idx, want.x, want.y, want.z, want.ov, want.oa);
            $display("                      got x=%0d y=%0d z=%0d ov=%0d oa=%0d",
                     pos_x, pos_y, pos_z, orient_valid, orient_angle);
          end
        end
      end
    end
    if (rst || in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer pending requests; hold the current one until it is taken
  always @(negedge clk) begin
    bit holding;
    holding = in_valid && !in_fire;
    if (!holding) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (index_q.size() > 0) begin
        in_valid <= 1'b1;
        item_index <= index_q.pop_front();
        if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the output in short bursts, or for a long stretch when asked
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Wait until every request has gone through and the pipeline is empty
  task automatic drain_pipeline();
    while (index_q.size() > 0 || in_valid || place_q.size() > 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Write one register, with junk above its width, and track it in the mirror
  task automatic write_reg(input logic [2:0] idx, input int value);
    logic [31:0] data;
    int wid;
    case (idx)
      REG_CIRCLE_RADIUS:               wid = 31;
      REG_START_ANGLE, REG_STEP_ANGLE: wid = 16;
      REG_AXIS_SELECT:                 wid = 2;
      REG_FOLLOW_ROTATION:             wid = 1;
      default:                         wid = 32;
    endcase
    data = value;
    if (wid < 32) data = (data & ((32'd1 << wid) - 32'd1)) | ($urandom() << wid);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    case (idx)
      REG_CENTER_X:      cfg_cx = data;
      REG_CENTER_Y:      cfg_cy = data;
      REG_CENTER_Z:      cfg_cz = data;
      REG_CIRCLE_RADIUS: cfg_radius = data[30:0];
      REG_START_ANGLE:   cfg_start = data[15:0];
      REG_STEP_ANGLE:    cfg_step = data[15:0];
      REG_AXIS_SELECT:   cfg_axis = data[1:0];
      default:           cfg_follow = data[0];
    endcase
    @(posedge clk);
  endtask

  task automatic load_setting(input int cx, input int cy, input int cz, input int radius,
                              input int start, input int step, input int axis,
                              input int follow);
    drain_pipeline();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_CIRCLE_RADIUS, radius);
    write_reg(REG_START_ANGLE, start);
    write_reg(REG_STEP_ANGLE, step);
    write_reg(REG_AXIS_SELECT, axis);
    write_reg(REG_FOLLOW_ROTATION, follow);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2, 3:    return int'($urandom_range(0, 2000000000)) - 1000000000;
      default: return int'($urandom());
    endcase
  endfunction

  initial begin
    int radius, step, n, len;
    logic [15:0] base;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // largest radius, all four quadrants and the fold boundary
    load_setting(0, 0, 0, 2147483647, 0, 1, AXIS_Z, 1);
    index_q = '{16'd0, 16'd16383, 16'd16384, 16'd16385, 16'd32768, 16'd49152, 16'd65535};

    // saturation high and low, no follow, X axis
    load_setting(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 2147483647, 49152, 16384,
                 AXIS_X, 0);
    index_q = '{16'd0, 16'd1, 16'd2, 16'd65535};

    // zero step on the Y axis
    load_setting(-123456789, 98765432, 5, 1000000, 65535, 0, AXIS_Y, 1);
    index_q = '{16'd0, 16'd12345, 16'd65535};

    // unused axis code leaves the item at the center
    load_setting(11, -22, 33, 3 << 16, 100, -32768, AXIS_NONE, 1);
    index_q = '{16'd0, 16'd1, 16'hAAAA, 16'h5555};

    // zero radius, most positive step
    load_setting(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 32767, AXIS_Z, 1);
    index_q = '{16'd65535, 16'd2};

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       radius = 2147483647;
        1:       radius = $urandom_range(0, 32'h00400000);
        default: radius = $urandom() & 32'h7FFFFFFF;
      endcase
      case ($urandom_range(0, 5))
        0:       step = 0;
        1:       step = 1;
        2:       step = -1;
        3:       step = 32767;
        4:       step = -32768;
        default: step = int'($urandom_range(0, 65535)) - 32768;
      endcase
      load_setting(pick_coord(), pick_coord(), pick_coord(), radius,
                   $urandom_range(0, 65535), step, $urandom_range(0, 3),
                   $urandom_range(0, 1));
      if (ph >= QUIET_PHASE) quiet = 1'b1;
      // mostly scattered indices, some runs around the ring, some extremes
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 7))
          0: begin
            base = 16'($urandom_range(0, 65535));
            len = $urandom_range(4, 16);
            for (int k = 0; k < len; k++) index_q = {index_q, base + k[15:0]};
            n += len;
          end
          1: begin
            index_q = {index_q, ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
            n++;
          end
          default: begin
            index_q = {index_q, 16'($urandom_range(0, 65535))};
            n++;
          end
        endcase
      end
      // back up the output long enough to fill the pipeline
      if (ph == HOLD_PHASE) begin
        @(posedge clk);
        hold_asks++;
      end
    end

    drain_pipeline();
    if (mismatch_count == 0 && place_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
